// ===== rtl/core/cws_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Shared constants and types for the circle wipe span block
package cws_pkg;

	// Default field widths
	localparam int COORD_BITS_DEF = 12;
	localparam int STEP_BITS_DEF  = 16;

	// Entries in the queue between the front and back parts (power of two)
	localparam int QUEUE_DEPTH = 4;

	// Register values after reset
	localparam int SCREEN_WIDTH_RESET  = 640;
	localparam int SCREEN_HEIGHT_RESET = 480;
	localparam int MAX_STEP_RESET      = 1;

	// Width of the register index on the write port
	localparam int CFG_INDEX_BITS = 2;

	// Register indexes
	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_SCREEN_WIDTH  = 2'd0,
		REG_SCREEN_HEIGHT = 2'd1,
		REG_MAX_STEP      = 2'd2
	} cfg_reg_t;

	// Full radius sequencer states
	typedef enum logic [1:0] {
		RAD_LOAD,
		RAD_RUN,
		RAD_IDLE
	} rad_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/cws_radius.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Iterative square root giving the full radius, isqrt(hw^2 + hh^2) + 1.
// One result bit per cycle; restarts whenever a register is written.
module cws_radius #(
	parameter int COORD_BITS = cws_pkg::COORD_BITS_DEF,
	localparam int CNT_W = $clog2(COORD_BITS)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [COORD_BITS-2:0] half_w,
	input  wire logic [COORD_BITS-2:0] half_h,
	output logic                       busy,
	output logic [COORD_BITS-1:0]      full_radius
);

	cws_pkg::rad_state_t state_q, state_d;

	logic [2*COORD_BITS-1:0] rad_q;
	logic [COORD_BITS-1:0]   root_q;
	logic [COORD_BITS:0]     rem_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [COORD_BITS-1:0]   full_q;

	logic                    load_en, run_en, last;
	logic [2*COORD_BITS-1:0] rad_sum;
	logic [COORD_BITS+2:0]   trial, part, diff;
	logic                    ge;
	logic [COORD_BITS-1:0]   root_nxt;
	logic [COORD_BITS:0]     rem_nxt;

	assign last = (cnt_q == CNT_W'(COORD_BITS - 1));

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			cws_pkg::RAD_LOAD: state_d = cws_pkg::RAD_RUN;
			cws_pkg::RAD_RUN:  state_d = last ? cws_pkg::RAD_IDLE : cws_pkg::RAD_RUN;
			cws_pkg::RAD_IDLE: state_d = cws_pkg::RAD_IDLE;
			default:           state_d = cws_pkg::RAD_LOAD;
		endcase
		if (start) begin
			state_d = cws_pkg::RAD_LOAD;
		end
	end

	// State outputs
	always_comb begin
		load_en = 1'b0;
		run_en  = 1'b0;
		busy    = 1'b1;
		case (state_q)
			cws_pkg::RAD_LOAD: load_en = 1'b1;
			cws_pkg::RAD_RUN:  run_en  = 1'b1;
			cws_pkg::RAD_IDLE: busy    = 1'b0;
			default:           busy    = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cws_pkg::RAD_LOAD;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (load_en) begin
				cnt_q <= '0;
			end else if (run_en) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	// Radicand from the half sizes
	assign rad_sum = ({{(COORD_BITS+1){1'b0}}, half_w} * {{(COORD_BITS+1){1'b0}}, half_w})
		+ ({{(COORD_BITS+1){1'b0}}, half_h} * {{(COORD_BITS+1){1'b0}}, half_h});

	// One digit of the root per cycle
	assign part     = {rem_q, rad_q[2*COORD_BITS-1 -: 2]};
	assign trial    = {1'b0, root_q, 2'b01};
	assign ge       = (part >= trial);
	assign diff     = part - trial;
	assign root_nxt = {root_q[COORD_BITS-2:0], ge};
	assign rem_nxt  = ge ? diff[COORD_BITS:0] : part[COORD_BITS:0];

	always_ff @(posedge clk) begin
		if (load_en) begin
			rad_q  <= rad_sum;
			root_q <= '0;
			rem_q  <= '0;
		end else if (run_en) begin
			rad_q  <= {rad_q[2*COORD_BITS-3:0], 2'b00};
			root_q <= root_nxt;
			rem_q  <= rem_nxt;
			if (last) begin
				full_q <= root_nxt + COORD_BITS'(1);
			end
		end
	end

	assign full_radius = full_q;

endmodule

`default_nettype wire

// ===== rtl/core/cws_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Front part: registers, full radius, request intake and classification.
// Clamps the step, folds the row about the centre and forms step * full.
module cws_front #(
	parameter int COORD_BITS = cws_pkg::COORD_BITS_DEF,
	parameter int STEP_BITS  = cws_pkg::STEP_BITS_DEF,
	localparam int CFG_W = (COORD_BITS > STEP_BITS) ? COORD_BITS : STEP_BITS,
	localparam int QW    = 2*COORD_BITS + STEP_BITS
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [cws_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  wire logic [CFG_W-1:0]                    cfg_data,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [STEP_BITS-1:0]                frame_step,
	input  wire logic [COORD_BITS-1:0]               row,
	output logic                                     push,
	output logic [QW-1:0]                            push_data,
	input  wire logic                                q_full,
	output logic [COORD_BITS-1:0]                    scr_width,
	output logic [STEP_BITS-1:0]                     max_eff
);

	logic [COORD_BITS-1:0] width_q, height_q;
	logic [STEP_BITS-1:0]  max_step_q;

	logic                  rad_busy;
	logic [COORD_BITS-1:0] full_radius;
	logic [COORD_BITS-1:0] half_h;
	logic [STEP_BITS-1:0]  st_c;
	logic [COORD_BITS-1:0] y_c;
	logic                  accept;

	logic                  vld_s1;
	logic [STEP_BITS-1:0]  st_s1;
	logic [COORD_BITS-1:0] y_s1;

	logic [STEP_BITS+COORD_BITS-1:0] num;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= COORD_BITS'(cws_pkg::SCREEN_WIDTH_RESET);
			height_q   <= COORD_BITS'(cws_pkg::SCREEN_HEIGHT_RESET);
			max_step_q <= STEP_BITS'(cws_pkg::MAX_STEP_RESET);
		end else if (cfg_we) begin
			case (cws_pkg::cfg_reg_t'(cfg_index))
				cws_pkg::REG_SCREEN_WIDTH:  width_q    <= cfg_data[COORD_BITS-1:0];
				cws_pkg::REG_SCREEN_HEIGHT: height_q   <= cfg_data[COORD_BITS-1:0];
				cws_pkg::REG_MAX_STEP:      max_step_q <= cfg_data[STEP_BITS-1:0];
				default: ;
			endcase
		end
	end

	cws_radius #(
		.COORD_BITS (COORD_BITS)
	) u_radius (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (cfg_we),
		.half_w      (width_q[COORD_BITS-1:1]),
		.half_h      (height_q[COORD_BITS-1:1]),
		.busy        (rad_busy),
		.full_radius (full_radius)
	);

	assign scr_width = width_q;
	assign max_eff   = (max_step_q == '0) ? STEP_BITS'(1) : max_step_q;
	assign half_h    = {1'b0, height_q[COORD_BITS-1:1]};

	// Classify the incoming request
	assign st_c = (frame_step > max_eff) ? max_eff : frame_step;
	assign y_c  = (row >= half_h) ? (row - half_h) : (half_h - row);

	assign in_ready = !rad_busy && (!vld_s1 || !q_full);
	assign accept   = in_valid && in_ready;
	assign push     = vld_s1 && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (push) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			st_s1 <= st_c;
			y_s1  <= y_c;
		end
	end

	// Dividend of the radius: step * full radius
	assign num = {{COORD_BITS{1'b0}}, st_s1} * {{STEP_BITS{1'b0}}, full_radius};

	assign push_data = {y_s1, num};

endmodule

`default_nettype wire

// ===== rtl/core/cws_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Small register queue between the front and back parts
module cws_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = cws_pkg::QUEUE_DEPTH,
	localparam int PTR_W = $clog2(DEPTH),
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      pop_data,
	output logic                  empty
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/cws_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Back part: radius divider, squares, difference, rounded root and span.
// Every stage moves on one shared enable; the output register is the last.
module cws_back #(
	parameter int COORD_BITS = cws_pkg::COORD_BITS_DEF,
	parameter int STEP_BITS  = cws_pkg::STEP_BITS_DEF,
	localparam int QW = 2*COORD_BITS + STEP_BITS,
	localparam int CB = COORD_BITS,
	localparam int SB = STEP_BITS,
	localparam int PL = 2*COORD_BITS + 2
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  q_empty,
	input  wire logic [QW-1:0]         q_data,
	output logic                       pop,
	input  wire logic [CB-1:0]         scr_width,
	input  wire logic [SB-1:0]         max_eff,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [CB-1:0]              left_margin,
	output logic [CB-1:0]              inside_width,
	output logic [CB-1:0]              right_margin
);

	logic en;

	logic [PL-1:0] vld_s;

	// Divider stages
	logic [SB-1:0]   div_rem_s  [1:CB-1];
	logic [CB-1:0]   div_nq_s   [1:CB];
	logic [CB-1:0]   div_y_s    [1:CB];

	// Square and difference stages
	logic [2*CB-1:0] sqr_r2_s, sqr_y2_s;
	logic            dif_pos_s;
	logic [2*CB-1:0] dif_d_s;

	// Root stages
	logic [2*CB-1:0] rt_d_s     [1:CB-1];
	logic [CB-1:0]   rt_root_s  [1:CB];
	logic [CB:0]     rt_rem_s   [1:CB];
	logic            rt_pos_s   [1:CB];

	// Span and output register
	logic [CB:0]     s_f, hw_f, hms_f;
	logic            rnd, big;
	logic [CB-1:0]   left_d, inside_d, right_d;
	logic            out_valid_q;
	logic [CB-1:0]   out_left_q, out_inside_q, out_right_q;

	assign en  = !out_valid_q || out_ready;
	assign pop = en && !q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s       <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			vld_s       <= {vld_s[PL-2:0], pop};
			out_valid_q <= vld_s[PL-1];
		end
	end

	// Restoring division, one quotient bit per stage; quotient fits CB bits
	// because the clamped step never exceeds the divisor.
	for (genvar k = 0; k < CB; k++) begin : g_div
		logic [SB-1:0] rem_i;
		logic [CB-1:0] nq_i, y_i;
		logic [SB:0]   part, diff;
		logic          ge;

		if (k == 0) begin : g_in
			assign rem_i = q_data[SB+CB-1:CB];
			assign nq_i  = q_data[CB-1:0];
			assign y_i   = q_data[QW-1:SB+CB];
		end else begin : g_in
			assign rem_i = div_rem_s[k];
			assign nq_i  = div_nq_s[k];
			assign y_i   = div_y_s[k];
		end

		assign part = {rem_i, nq_i[CB-1]};
		assign ge   = (part >= {1'b0, max_eff});
		assign diff = part - {1'b0, max_eff};

		always_ff @(posedge clk) begin
			if (en) begin
				div_nq_s[k+1] <= {nq_i[CB-2:0], ge};
				div_y_s[k+1]  <= y_i;
			end
		end

		if (k < CB - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					div_rem_s[k+1] <= ge ? diff[SB-1:0] : part[SB-1:0];
				end
			end
		end
	end

	// Squares of radius and row offset
	always_ff @(posedge clk) begin
		if (en) begin
			sqr_r2_s <= {{CB{1'b0}}, div_nq_s[CB]} * {{CB{1'b0}}, div_nq_s[CB]};
			sqr_y2_s <= {{CB{1'b0}}, div_y_s[CB]} * {{CB{1'b0}}, div_y_s[CB]};
		end
	end

	// Radicand and whether the row meets the circle at all
	always_ff @(posedge clk) begin
		if (en) begin
			dif_pos_s <= (sqr_r2_s > sqr_y2_s);
			dif_d_s   <= sqr_r2_s - sqr_y2_s;
		end
	end

	// Digit-by-digit square root, one result bit per stage
	for (genvar k = 0; k < CB; k++) begin : g_root
		localparam int J = CB - 1 - k;
		logic [2*CB-1:0] d_i;
		logic [CB-1:0]   root_i;
		logic [CB:0]     rem_i;
		logic            pos_i;
		logic [CB+2:0]   part, trial, diff;
		logic            ge;

		if (k == 0) begin : g_in
			assign d_i    = dif_d_s;
			assign root_i = '0;
			assign rem_i  = '0;
			assign pos_i  = dif_pos_s;
		end else begin : g_in
			assign d_i    = rt_d_s[k];
			assign root_i = rt_root_s[k];
			assign rem_i  = rt_rem_s[k];
			assign pos_i  = rt_pos_s[k];
		end

		assign part  = {rem_i, d_i[2*J +: 2]};
		assign trial = {1'b0, root_i, 2'b01};
		assign ge    = (part >= trial);
		assign diff  = part - trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rt_root_s[k+1] <= {root_i[CB-2:0], ge};
				rt_rem_s[k+1]  <= ge ? diff[CB:0] : part[CB:0];
				rt_pos_s[k+1]  <= pos_i;
			end
		end

		if (k < CB - 1) begin : g_d
			always_ff @(posedge clk) begin
				if (en) begin
					rt_d_s[k+1] <= d_i;
				end
			end
		end
	end

	// Round half up: remainder above the root means the next integer
	assign rnd   = (rt_rem_s[CB] > {1'b0, rt_root_s[CB]});
	assign s_f   = {1'b0, rt_root_s[CB]} + {{CB{1'b0}}, rnd};
	assign hw_f  = {2'b00, scr_width[CB-1:1]};
	assign big   = (s_f >= hw_f);
	assign hms_f = hw_f - s_f;

	// Span selection
	always_comb begin
		if (!rt_pos_s[CB]) begin
			left_d   = scr_width;
			inside_d = '0;
			right_d  = '0;
		end else if (big) begin
			left_d   = '0;
			inside_d = scr_width;
			right_d  = '0;
		end else begin
			left_d   = hms_f[CB-1:0];
			inside_d = {s_f[CB-2:0], 1'b0};
			right_d  = hms_f[CB-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_left_q   <= left_d;
			out_inside_q <= inside_d;
			out_right_q  <= right_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign left_margin  = out_left_q;
	assign inside_width = out_inside_q;
	assign right_margin = out_right_q;

endmodule

`default_nettype wire

// ===== rtl/core/circle_wipe_row_span.sv =====
// Circle wipe row span: for each request (wipe step, scanline row) gives
// the pixels left of, inside and right of a screen-centred circle whose
// radius grows linearly with the step until it reaches the corners. It
// takes one request per cycle sustained while m_tready stays high; a stall
// on m_tready freezes the back part, and s_tready drops once the queue and
// the front register have filled. A request passes the front register, the
// queue, a COORD_BITS-stage radius divider, square and difference stages,
// a COORD_BITS-stage square root and the output register before m_tvalid
// rises. After reset and after every register write the full radius is
// recomputed by an iterative root unit, one bit a cycle, and s_tready
// stays low until it is done.
`timescale 1ns / 1ps
`default_nettype none

module circle_wipe_row_span #(
	parameter int COORD_BITS = cws_pkg::COORD_BITS_DEF,
	parameter int STEP_BITS  = cws_pkg::STEP_BITS_DEF,
	localparam int CFG_W = (COORD_BITS > STEP_BITS) ? COORD_BITS : STEP_BITS,
	localparam int IN_W  = ((STEP_BITS + COORD_BITS + 7) / 8) * 8,
	localparam int OUT_W = ((3*COORD_BITS + 7) / 8) * 8,
	localparam int QW    = 2*COORD_BITS + STEP_BITS
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// register write port
	input  wire logic                               cfg_we,
	input  wire logic [cws_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]                   cfg_data,
	// request stream
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	input  wire logic [IN_W-1:0]                    s_tdata,  // frame_step, row
	// result stream
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	output logic [OUT_W-1:0]                        m_tdata   // left, inside, right
);

	logic                  push, q_full, pop, q_empty;
	logic [QW-1:0]         push_data, pop_data;
	logic [COORD_BITS-1:0] scr_width;
	logic [STEP_BITS-1:0]  max_eff;
	logic [COORD_BITS-1:0] left_margin, inside_width, right_margin;

	cws_front #(
		.COORD_BITS (COORD_BITS),
		.STEP_BITS  (STEP_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.frame_step (s_tdata[STEP_BITS-1:0]),
		.row        (s_tdata[STEP_BITS+COORD_BITS-1:STEP_BITS]),
		.push       (push),
		.push_data  (push_data),
		.q_full     (q_full),
		.scr_width  (scr_width),
		.max_eff    (max_eff)
	);

	cws_queue #(
		.WIDTH (QW),
		.DEPTH (cws_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (q_empty)
	);

	cws_back #(
		.COORD_BITS (COORD_BITS),
		.STEP_BITS  (STEP_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_data       (pop_data),
		.pop          (pop),
		.scr_width    (scr_width),
		.max_eff      (max_eff),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.left_margin  (left_margin),
		.inside_width (inside_width),
		.right_margin (right_margin)
	);

	assign m_tdata = OUT_W'({right_margin, inside_width, left_margin});

endmodule

`default_nettype wire

// ===== rtl/core/cws_check.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Port-level checks for the circle wipe span block
module cws_check #(
	parameter int COORD_BITS = cws_pkg::COORD_BITS_DEF,
	parameter int STEP_BITS  = cws_pkg::STEP_BITS_DEF,
	localparam int CFG_W = (COORD_BITS > STEP_BITS) ? COORD_BITS : STEP_BITS,
	localparam int IN_W  = ((STEP_BITS + COORD_BITS + 7) / 8) * 8,
	localparam int OUT_W = ((3*COORD_BITS + 7) / 8) * 8
) (
	input wire logic                               clk,
	input wire logic                               arst_n,
	input wire logic                               cfg_we,
	input wire logic [cws_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input wire logic [CFG_W-1:0]                   cfg_data,
	input wire logic                               s_tvalid,
	input wire logic                               s_tready,
	input wire logic [IN_W-1:0]                    s_tdata,
	input wire logic                               m_tvalid,
	input wire logic                               m_tready,
	input wire logic [OUT_W-1:0]                   m_tdata
);

	logic [7:0]            pend_q;
	logic                  in_acc, out_acc;
	logic [COORD_BITS-1:0] left, inner_w, right;

	assign in_acc  = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;
	assign left    = m_tdata[COORD_BITS-1:0];
	assign inner_w = m_tdata[2*COORD_BITS-1:COORD_BITS];
	assign right   = m_tdata[3*COORD_BITS-1:2*COORD_BITS];

	// Requests taken but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (in_acc && !out_acc) begin
			pend_q <= pend_q + 8'd1;
		end else if (out_acc && !in_acc) begin
			pend_q <= pend_q - 8'd1;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> pend_q != '0)
		else $error("result without a pending request");

	a_symmetric: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (right == '0) || (left == right))
		else $error("span margins differ");

	a_even: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (right != '0) |-> inner_w[0] == 1'b0)
		else $error("inner span width is odd");

	a_recompute: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !s_tready)
		else $error("request taken while full radius is recomputed");

endmodule

bind circle_wipe_row_span cws_check #(
	.COORD_BITS (COORD_BITS),
	.STEP_BITS  (STEP_BITS)
) u_cws_check (.*);

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

	localparam int CB = 12;
	localparam int SB = 16;

	// One row span, as it travels on the result bus
	typedef struct packed {
		logic [CB-1:0] right_margin;
		logic [CB-1:0] inside_width;
		logic [CB-1:0] left_margin;
	} span_t;

	logic          clk;
	logic          arst_n;
	logic          cfg_we;
	logic [1:0]    cfg_index;
	logic [15:0]   cfg_data;
	logic          s_tvalid;
	logic          s_tready;
	logic [31:0]   s_tdata;
	logic          m_tvalid;
	logic          m_tready;
	logic [39:0]   m_tdata;

	// Register copies held by the predictor
	logic [CB-1:0] scr_w    = CB'(cws_pkg::SCREEN_WIDTH_RESET);
	logic [CB-1:0] scr_h    = CB'(cws_pkg::SCREEN_HEIGHT_RESET);
	logic [SB-1:0] wipe_len = SB'(cws_pkg::MAX_STEP_RESET);

	span_t span_due[$];
	int    mismatch_count   = 0;
	bit    send_gaps_on     = 1'b1;
	bit    recv_stalls_on   = 1'b1;
	int    recv_hold_cycles = 0;

	circle_wipe_row_span dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),   // frame_step [15:0], row [27:16]
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)    // left [11:0], inside [23:12], right [35:24]
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Floor of the square root, built up one result bit at a time
	function automatic logic [31:0] root_floor(input logic [31:0] v);
		logic [63:0] trial;
		logic [31:0] res;
		res = '0;
		for (int b = 15; b >= 0; b--) begin
			trial = 64'(res | (32'd1 << b));
			if (trial * trial <= 64'(v))
				res = trial[31:0];
		end
		return res;
	endfunction

	// Span of the circle on one row under the current register settings
	function automatic span_t span_of_row(input logic [SB-1:0] step, input logic [CB-1:0] row);
		logic [31:0] hw, hh, m, st, full, r, r2, ay, y2, d, q, s;
		span_t res;
		hw = 32'(scr_w >> 1);
		hh = 32'(scr_h >> 1);
		m = (wipe_len == '0) ? 32'd1 : 32'(wipe_len);
		st = (32'(step) > m) ? m : 32'(step);
		full = root_floor(hw * hw + hh * hh) + 32'd1;
		r = (st * full) / m;
		r2 = r * r;
		ay = (32'(row) >= hh) ? 32'(row) - hh : hh - 32'(row);
		y2 = ay * ay;
		res = '0;
		if (r2 <= y2) begin
			res.left_margin = scr_w;
		end else begin
			d = r2 - y2;
			q = root_floor(d);
			// round half up
			s = (d - q * q > q) ? q + 32'd1 : q;
			if (s >= hw) begin
				res.inside_width = scr_w;
			end else begin
				res.left_margin  = CB'(hw - s);
				res.inside_width = CB'(2 * s);
				res.right_margin = CB'(hw - s);
			end
		end
		return res;
	endfunction

	// Offer one request, hold it until taken, then maybe leave a gap
	task automatic offer_row(input logic [SB-1:0] step, input logic [CB-1:0] row);
		s_tdata <= {4'd0, row, step};
		if (!s_tvalid)
			s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		span_due.push_back(span_of_row(step, row));
		if (send_gaps_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
	endtask

	// Stop offering and wait for every outstanding span
	task automatic await_spans();
		if (s_tvalid)
			s_tvalid <= 1'b0;
		while (span_due.size() != 0)
			@(posedge clk);
	endtask

	// Register write, only once the block has gone idle
	task automatic write_reg(input cws_pkg::cfg_reg_t idx, input logic [15:0] val);
		await_spans();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			cws_pkg::REG_SCREEN_WIDTH:  scr_w = val[CB-1:0];
			cws_pkg::REG_SCREEN_HEIGHT: scr_h = val[CB-1:0];
			cws_pkg::REG_MAX_STEP:      wipe_len = val[SB-1:0];
			default: ;
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Receiver: random stalls, plus a long hold-off when asked
	initial begin
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (recv_hold_cycles > 0) begin
				m_tready <= 1'b0;
				repeat (recv_hold_cycles) @(posedge clk);
				recv_hold_cycles = 0;
			end else if (recv_stalls_on && $urandom_range(0, 2) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	// Compare each result against the oldest prediction
	always @(posedge clk) begin
		span_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[3*CB-1:0];
			if (span_due.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result: left %0d inside %0d right %0d",
						got.left_margin, got.inside_width, got.right_margin);
			end else begin
				want = span_due.pop_front();
				if (got !== want) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: left %0d/%0d inside %0d/%0d right %0d/%0d (exp/got)",
							want.left_margin, got.left_margin,
							want.inside_width, got.inside_width,
							want.right_margin, got.right_margin);
				end
			end
		end
	end

	// Reset settings: 640x480, one-step wipe
	task automatic test_defaults();
		offer_row(16'd0, 12'd240);
		offer_row(16'd1, 12'd240);
		offer_row(16'd1, 12'd0);
		offer_row(16'hFFFF, 12'd479);
		offer_row(16'd1, 12'hFFF);
	endtask

	// Register extremes: zero wipe length, tiny and huge screens, ignored upper bits
	task automatic test_register_extremes();
		write_reg(cws_pkg::REG_MAX_STEP, 16'd0);
		offer_row(16'd0, 12'd240);
		offer_row(16'hFFFF, 12'd100);

		write_reg(cws_pkg::REG_MAX_STEP, 16'hFFFF);
		write_reg(cws_pkg::REG_SCREEN_WIDTH, 16'd4095);
		write_reg(cws_pkg::REG_SCREEN_HEIGHT, 16'd4095);
		offer_row(16'h8000, 12'd2047);
		offer_row(16'hFFFF, 12'd0);
		offer_row(16'd1, 12'd2047);
		offer_row(16'hFFFF, 12'hFFF);

		// width of one, upper data bits set
		write_reg(cws_pkg::REG_SCREEN_WIDTH, 16'hF001);
		write_reg(cws_pkg::REG_SCREEN_HEIGHT, 16'd480);
		offer_row(16'hFFFF, 12'd240);
		offer_row(16'd0, 12'd240);

		write_reg(cws_pkg::REG_SCREEN_WIDTH, 16'd0);
		write_reg(cws_pkg::REG_SCREEN_HEIGHT, 16'd0);
		offer_row(16'hFFFF, 12'd0);
		offer_row(16'd0, 12'd0);

		write_reg(cws_pkg::REG_SCREEN_WIDTH, 16'hA280);
		write_reg(cws_pkg::REG_SCREEN_HEIGHT, 16'h51E0);
		write_reg(cws_pkg::REG_MAX_STEP, 16'd8);
		offer_row(16'd4, 12'd240);
		offer_row(16'd3, 12'd100);
		offer_row(16'd8, 12'd479);
		offer_row(16'd9, 12'd0);
	endtask

	function automatic logic [SB-1:0] pick_step();
		logic [31:0] m;
		m = (wipe_len == '0) ? 32'd1 : 32'(wipe_len);
		if ($urandom_range(0, 4) == 0)
			return SB'($urandom_range(0, 65535));
		return SB'($urandom_range(0, m));
	endfunction

	function automatic logic [CB-1:0] pick_row();
		if ($urandom_range(0, 4) == 0 || scr_h == '0)
			return CB'($urandom_range(0, 4095));
		return CB'($urandom_range(0, scr_h - 1));
	endfunction

	// Output held off for long while requests keep coming: the block must fill up
	task automatic test_full_stall();
		bit gaps_saved;
		gaps_saved = send_gaps_on;
		send_gaps_on = 1'b0;
		recv_hold_cycles = 250;
		repeat (60) offer_row(pick_step(), pick_row());
		send_gaps_on = gaps_saved;
		await_spans();
	endtask

	// New random geometry and wipe length, then a run of random rows
	task automatic test_random_phase(input int n);
		logic [15:0] w, h, m;
		w = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 64)) : 16'($urandom_range(1, 4095));
		h = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 64)) : 16'($urandom_range(1, 4095));
		case ($urandom_range(0, 3))
			0: m = 16'($urandom_range(0, 4));
			1: m = 16'($urandom_range(1, 64));
			2: m = 16'($urandom_range(1, 4096));
			default: m = 16'($urandom_range(0, 65535));
		endcase
		w[15:12] = 4'($urandom);
		h[15:12] = 4'($urandom);
		write_reg(cws_pkg::REG_SCREEN_WIDTH, w);
		write_reg(cws_pkg::REG_SCREEN_HEIGHT, h);
		write_reg(cws_pkg::REG_MAX_STEP, m);
		repeat (n) offer_row(pick_step(), pick_row());
	endtask

	initial begin
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = cws_pkg::REG_SCREEN_WIDTH;
		cfg_data  = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_defaults();
		test_register_extremes();
		test_full_stall();
		for (int p = 0; p < 6; p++)
			test_random_phase(150);
		// last stretch runs flat out on both sides
		send_gaps_on = 1'b0;
		recv_stalls_on = 1'b0;
		test_random_phase(100);

		await_spans();
		repeat (40) @(posedge clk);
		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// Watchdog
	initial begin
		#(2_000_000);
		$display("FAILURE");
		$finish;
	end

endmodule
